// File: rtl/rmspn_pkg.sv
package rmspn_pkg;

   localparam int DATA_W           = 32;
   localparam int IDX_W            = 12;
   localparam int NUM_ELEMENTS_DEF = 4096;

   localparam int LR_W     = 24;
   localparam int DECAY_W  = 16;
   localparam int DELTA_W  = 25;
   localparam int MOM_W    = 16;
   localparam int CSR_W    = 25;
   localparam int CSR_IDX_W = 2;

   localparam int CACHE_W  = 32;
   localparam int MV_W     = 33;
   localparam int GSQ_W    = 39;
   localparam int NUM_W    = 56;
   localparam int SQ_IN_W  = 56;
   localparam int ROOT_W   = 28;
   localparam int DEN_W    = 29;
   localparam int DVD_W    = 57;

   localparam logic [LR_W-1:0]    LR_RESET    = LR_W'(16777);
   localparam logic [DECAY_W-1:0] DECAY_RESET = DECAY_W'(58982);
   localparam logic [DELTA_W-1:0] DELTA_RESET = DELTA_W'(17);
   localparam logic [MOM_W-1:0]   MOM_RESET   = MOM_W'(58982);

   localparam logic FUNC_LOOKAHEAD = 1'b0;
   localparam logic FUNC_UPDATE    = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_LEARNING_RATE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DECAY_RATE      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STABILITY_DELTA = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MOMENTUM        = 2'd3;

   localparam logic signed [63:0] SAT_HI = (64'sd1 <<< (DATA_W - 1)) - 64'sd1;
   localparam logic signed [63:0] SAT_LO = -SAT_HI - 64'sd1;

   typedef struct packed {
      logic             func;
      logic [IDX_W-1:0] idx;
      logic             in_range;
   } tag_type;

   typedef struct packed {
      tag_type                   tag;
      logic                      g_neg;
      logic signed [DATA_W-1:0]  pres;
      logic signed [MV_W-1:0]    mv;
      logic [CACHE_W-1:0]        cache;
      logic                      flag;
      logic [NUM_W-1:0]          num;
   } side_type;

   typedef struct packed {
      logic                     ovf;
      logic signed [DATA_W-1:0] val;
   } sat_type;

   function automatic sat_type sat_data(input logic signed [63:0] x);
      sat_type r;
      r.ovf = 1'b0;
      r.val = x[DATA_W-1:0];
      if (x > SAT_HI) begin
         r.ovf = 1'b1;
         r.val = SAT_HI[DATA_W-1:0];
      end else if (x < SAT_LO) begin
         r.ovf = 1'b1;
         r.val = SAT_LO[DATA_W-1:0];
      end
      return r;
   endfunction

   // An in-flight update that will write the probed element.
   function automatic logic tag_hit(input logic valid, input tag_type tag,
                                    input logic [IDX_W-1:0] probe);
      return valid && (tag.func == FUNC_UPDATE) && tag.in_range && (tag.idx == probe);
   endfunction

endpackage

// File: rtl/rmspn_if.sv
interface rmspn_req_if;
   logic                                    valid;
   logic                                    ready;
   logic                                    func;
   logic [rmspn_pkg::IDX_W-1:0]             element_index;
   logic signed [rmspn_pkg::DATA_W-1:0]     parameter_value;
   logic signed [rmspn_pkg::DATA_W-1:0]     gradient_value;

   modport source(output valid, func, element_index, parameter_value, gradient_value,
                  input ready);
   modport sink(input valid, func, element_index, parameter_value, gradient_value,
                output ready);
endinterface

interface rmspn_rsp_if;
   logic                                    valid;
   logic                                    ready;
   logic signed [rmspn_pkg::DATA_W-1:0]     new_parameter;
   logic [rmspn_pkg::IDX_W-1:0]             result_index;
   logic                                    saturated;

   modport source(output valid, new_parameter, result_index, saturated, input ready);
   modport sink(input valid, new_parameter, result_index, saturated, output ready);
endinterface

// File: rtl/rmspn_store.sv
module rmspn_store #(
   parameter int NUM_ELEMENTS = rmspn_pkg::NUM_ELEMENTS_DEF,
   localparam int ADDR_W = (NUM_ELEMENTS > 1) ? $clog2(NUM_ELEMENTS) : 1
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   rd_en,
   input  logic [ADDR_W-1:0]                      rd_addr,
   output logic [rmspn_pkg::CACHE_W-1:0]          rd_cache,
   output logic signed [rmspn_pkg::DATA_W-1:0]    rd_vel,
   input  logic                                   wr_en,
   input  logic [ADDR_W-1:0]                      wr_addr,
   input  logic [rmspn_pkg::CACHE_W-1:0]          wr_cache,
   input  logic signed [rmspn_pkg::DATA_W-1:0]    wr_vel,
   output logic                                   busy
);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(NUM_ELEMENTS - 1);

   logic [rmspn_pkg::CACHE_W-1:0]       cache_mem [NUM_ELEMENTS];
   logic signed [rmspn_pkg::DATA_W-1:0] vel_mem   [NUM_ELEMENTS];

   logic                                busy_ff;
   logic [ADDR_W-1:0]                   clr_addr_ff;
   logic [rmspn_pkg::CACHE_W-1:0]       rd_cache_ff;
   logic signed [rmspn_pkg::DATA_W-1:0] rd_vel_ff;

   // Sweep zeros through both arrays after reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b1;
         clr_addr_ff <= '0;
      end else if (busy_ff) begin
         if (clr_addr_ff == LAST_ADDR) begin
            busy_ff <= 1'b0;
         end else begin
            clr_addr_ff <= clr_addr_ff + ADDR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (busy_ff) begin
         cache_mem[clr_addr_ff] <= '0;
         vel_mem[clr_addr_ff]   <= '0;
      end else if (wr_en) begin
         cache_mem[wr_addr] <= wr_cache;
         vel_mem[wr_addr]   <= wr_vel;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_cache_ff <= cache_mem[rd_addr];
         rd_vel_ff   <= vel_mem[rd_addr];
      end
   end

   assign rd_cache = rd_cache_ff;
   assign rd_vel   = rd_vel_ff;
   assign busy     = busy_ff;

endmodule

// File: rtl/rmspn_sqrt.sv
module rmspn_sqrt (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              adv,
   input  logic                              in_valid,
   input  logic [rmspn_pkg::SQ_IN_W-1:0]     in_x,
   input  rmspn_pkg::side_type               in_side,
   input  logic [rmspn_pkg::IDX_W-1:0]       probe_idx,
   output logic                              out_valid,
   output logic [rmspn_pkg::ROOT_W-1:0]      out_root,
   output rmspn_pkg::side_type               out_side,
   output logic                              hit
);
   localparam int STAGES = rmspn_pkg::ROOT_W;
   localparam int RW     = rmspn_pkg::SQ_IN_W + 1;

   logic                valid_ff [STAGES];
   logic [RW-1:0]       rem_ff   [STAGES];
   logic [RW-1:0]       root_ff  [STAGES];
   rmspn_pkg::side_type side_ff  [STAGES];

   logic [RW-1:0]       src_rem  [STAGES];
   logic [RW-1:0]       src_root [STAGES];
   logic [RW-1:0]       bit_w    [STAGES];
   logic [RW-1:0]       trial    [STAGES];
   logic [RW-1:0]       rem_in   [STAGES];
   logic [RW-1:0]       root_in  [STAGES];
   logic [STAGES-1:0]   hit_vec;

   always_comb begin
      src_rem[0]  = {1'b0, in_x};
      src_root[0] = '0;
      for (int k = 1; k < STAGES; k++) begin
         src_rem[k]  = rem_ff[k-1];
         src_root[k] = root_ff[k-1];
      end
   end

   // One result bit per stage, from the top bit pair down.
   always_comb begin
      for (int k = 0; k < STAGES; k++) begin
         bit_w[k] = RW'(1) << (2 * (STAGES - 1 - k));
         trial[k] = src_root[k] + bit_w[k];
         if (src_rem[k] >= trial[k]) begin
            rem_in[k]  = src_rem[k] - trial[k];
            root_in[k] = (src_root[k] >> 1) + bit_w[k];
         end else begin
            rem_in[k]  = src_rem[k];
            root_in[k] = src_root[k] >> 1;
         end
         hit_vec[k] = rmspn_pkg::tag_hit(valid_ff[k], side_ff[k].tag, probe_idx);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < STAGES; k++) valid_ff[k] <= 1'b0;
      end else if (adv) begin
         valid_ff[0] <= in_valid;
         for (int k = 1; k < STAGES; k++) valid_ff[k] <= valid_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff[0] <= in_side;
         for (int k = 1; k < STAGES; k++) side_ff[k] <= side_ff[k-1];
         for (int k = 0; k < STAGES; k++) begin
            rem_ff[k]  <= rem_in[k];
            root_ff[k] <= root_in[k];
         end
      end
   end

   assign out_valid = valid_ff[STAGES-1];
   assign out_root  = root_ff[STAGES-1][rmspn_pkg::ROOT_W-1:0];
   assign out_side  = side_ff[STAGES-1];
   assign hit       = |hit_vec;

endmodule

// File: rtl/rmspn_div.sv
module rmspn_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              adv,
   input  logic                              in_valid,
   input  logic [rmspn_pkg::DVD_W-1:0]       in_dvd,
   input  logic [rmspn_pkg::DEN_W-1:0]       in_den,
   input  rmspn_pkg::side_type               in_side,
   input  logic [rmspn_pkg::IDX_W-1:0]       probe_idx,
   output logic                              out_valid,
   output logic [rmspn_pkg::DVD_W-1:0]       out_quo,
   output rmspn_pkg::side_type               out_side,
   output logic                              hit
);
   localparam int STAGES = rmspn_pkg::DVD_W;
   localparam int DW     = rmspn_pkg::DEN_W;

   logic                valid_ff [STAGES];
   logic [DW-1:0]       rem_ff   [STAGES];
   logic [STAGES-1:0]   quo_ff   [STAGES];
   logic [DW-1:0]       den_ff   [STAGES];
   rmspn_pkg::side_type side_ff  [STAGES];

   logic [DW-1:0]       src_rem  [STAGES];
   logic [STAGES-1:0]   src_quo  [STAGES];
   logic [DW-1:0]       src_den  [STAGES];
   logic [DW:0]         trial    [STAGES];
   logic [DW:0]         diff     [STAGES];
   logic                ge       [STAGES];
   logic [DW-1:0]       rem_in   [STAGES];
   logic [STAGES-1:0]   quo_in   [STAGES];
   logic [STAGES-1:0]   hit_vec;

   always_comb begin
      src_rem[0] = '0;
      src_quo[0] = in_dvd;
      src_den[0] = in_den;
      for (int k = 1; k < STAGES; k++) begin
         src_rem[k] = rem_ff[k-1];
         src_quo[k] = quo_ff[k-1];
         src_den[k] = den_ff[k-1];
      end
   end

   // Restoring division: shift in one dividend bit per stage.
   always_comb begin
      for (int k = 0; k < STAGES; k++) begin
         trial[k]  = {src_rem[k], src_quo[k][STAGES-1]};
         diff[k]   = trial[k] - {1'b0, src_den[k]};
         ge[k]     = trial[k] >= {1'b0, src_den[k]};
         rem_in[k] = ge[k] ? diff[k][DW-1:0] : trial[k][DW-1:0];
         quo_in[k] = {src_quo[k][STAGES-2:0], ge[k]};
         hit_vec[k] = rmspn_pkg::tag_hit(valid_ff[k], side_ff[k].tag, probe_idx);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < STAGES; k++) valid_ff[k] <= 1'b0;
      end else if (adv) begin
         valid_ff[0] <= in_valid;
         for (int k = 1; k < STAGES; k++) valid_ff[k] <= valid_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff[0] <= in_side;
         for (int k = 1; k < STAGES; k++) side_ff[k] <= side_ff[k-1];
         for (int k = 0; k < STAGES; k++) begin
            rem_ff[k] <= rem_in[k];
            quo_ff[k] <= quo_in[k];
            den_ff[k] <= src_den[k];
         end
      end
   end

   assign out_valid = valid_ff[STAGES-1];
   assign out_quo   = quo_ff[STAGES-1];
   assign out_side  = side_ff[STAGES-1];
   assign hit       = |hit_vec;

endmodule

// File: rtl/rmsprop_nesterov_update.sv
// RMSProp with Nesterov momentum, one element per beat.
// A result beat is presented after its request beat passes, in order, through capture with
// state read, 4 arithmetic stages, a 28-stage square root, the denominator stage, a 57-stage
// divider, the velocity and product stages and the output register.
// Throughput: one beat per cycle while the output is not stalled and no clearing pass runs;
// a beat that touches an element with an update still in the pipe waits until that update
// has written back. Reset: configuration returns to defaults, then a clearing pass over all
// NUM_ELEMENTS entries zeros both state arrays; no request beat is taken during that pass.
module rmsprop_nesterov_update #(
   parameter int NUM_ELEMENTS = rmspn_pkg::NUM_ELEMENTS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [rmspn_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [rmspn_pkg::CSR_W-1:0]         csr_data,
   rmspn_req_if.sink                           req_bus,
   rmspn_rsp_if.source                         rsp_bus
);
   localparam int DW     = rmspn_pkg::DATA_W;
   localparam int ADDR_W = (NUM_ELEMENTS > 1) ? $clog2(NUM_ELEMENTS) : 1;
   localparam int EXT_W  = ((ADDR_W > rmspn_pkg::IDX_W) ? ADDR_W : rmspn_pkg::IDX_W) + 1;

   // ---------------------------------------------------------------- registers
   logic [rmspn_pkg::LR_W-1:0]    lr_ff;
   logic [rmspn_pkg::DECAY_W-1:0] decay_ff;
   logic [rmspn_pkg::DELTA_W-1:0] delta_ff;
   logic [rmspn_pkg::MOM_W-1:0]   mom_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         lr_ff    <= rmspn_pkg::LR_RESET;
         decay_ff <= rmspn_pkg::DECAY_RESET;
         delta_ff <= rmspn_pkg::DELTA_RESET;
         mom_ff   <= rmspn_pkg::MOM_RESET;
      end else if (csr_we) begin
         case (csr_index)
            rmspn_pkg::CSR_LEARNING_RATE:   lr_ff    <= csr_data[rmspn_pkg::LR_W-1:0];
            rmspn_pkg::CSR_DECAY_RATE:      decay_ff <= csr_data[rmspn_pkg::DECAY_W-1:0];
            rmspn_pkg::CSR_STABILITY_DELTA: delta_ff <= csr_data[rmspn_pkg::DELTA_W-1:0];
            rmspn_pkg::CSR_MOMENTUM:        mom_ff   <= csr_data[rmspn_pkg::MOM_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------- handshake
   // The whole pipe moves as one; it holds only while the output register is
   // full and the sink is not taking it.
   logic adv;
   logic accept;
   logic hazard;
   logic busy;
   logic sqrt_hit;
   logic div_hit;

   logic rsp_valid_ff;
   logic signed [DW-1:0] rsp_param_ff;
   logic [rmspn_pkg::IDX_W-1:0] rsp_idx_ff;
   logic rsp_sat_ff;

   assign adv           = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = adv && !busy && !hazard;
   assign accept        = req_bus.valid && req_bus.ready;

   // ---------------------------------------------------------------- state store
   logic [EXT_W-1:0] req_idx_ext;
   logic             req_in_range;
   logic [rmspn_pkg::CACHE_W-1:0] rd_cache;
   logic signed [DW-1:0]          rd_vel;
   logic                          wr_en;
   logic [EXT_W-1:0]              wr_idx_ext;

   assign req_idx_ext  = EXT_W'(req_bus.element_index);
   assign req_in_range = req_idx_ext < EXT_W'(NUM_ELEMENTS);

   // stage and side registers declared ahead of the store hookup
   logic                    s0_valid_ff;
   rmspn_pkg::tag_type      s0_tag_ff;
   logic signed [DW-1:0]    s0_p_ff;
   logic signed [DW-1:0]    s0_g_ff;

   logic                    g_valid_ff;
   rmspn_pkg::side_type     g_side_ff;
   logic signed [DW-1:0]    g_vn_ff;
   logic signed [49:0]      g_prod_ff;

   assign wr_en      = g_valid_ff && adv && (g_side_ff.tag.func == rmspn_pkg::FUNC_UPDATE)
                       && g_side_ff.tag.in_range;
   assign wr_idx_ext = EXT_W'(g_side_ff.tag.idx);

   rmspn_store #(.NUM_ELEMENTS(NUM_ELEMENTS)) u_store (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (accept),
      .rd_addr  (req_idx_ext[ADDR_W-1:0]),
      .rd_cache (rd_cache),
      .rd_vel   (rd_vel),
      .wr_en    (wr_en),
      .wr_addr  (wr_idx_ext[ADDR_W-1:0]),
      .wr_cache (g_side_ff.cache),
      .wr_vel   (g_vn_ff),
      .busy     (busy)
   );

   // ---------------------------------------------------------------- stage S0
   // Capture the beat; the store read lands alongside it next cycle.
   always_ff @(posedge clock) begin
      if (reset) s0_valid_ff <= 1'b0;
      else if (adv) s0_valid_ff <= accept;
   end

   always_ff @(posedge clock) begin
      if (adv && accept) begin
         s0_tag_ff.func     <= req_bus.func;
         s0_tag_ff.idx      <= req_bus.element_index;
         s0_tag_ff.in_range <= req_in_range;
         s0_p_ff            <= req_bus.parameter_value;
         s0_g_ff            <= req_bus.gradient_value;
      end
   end

   // ---------------------------------------------------------------- stage A
   // Out-of-range elements read as zero state. Form m*v, g*g and lr*|g|.
   logic signed [DW-1:0]            s0_vel;
   logic [rmspn_pkg::CACHE_W-1:0]   s0_cache;
   logic [DW-1:0]                   s0_gabs;
   logic signed [48:0]              a_mvp_in;
   logic [63:0]                     a_gsqp_in;
   logic [rmspn_pkg::NUM_W-1:0]     a_num_in;

   assign s0_vel    = s0_tag_ff.in_range ? rd_vel : '0;
   assign s0_cache  = s0_tag_ff.in_range ? rd_cache : '0;
   assign s0_gabs   = s0_g_ff[DW-1] ? (~$unsigned(s0_g_ff) + DW'(1)) : $unsigned(s0_g_ff);
   assign a_mvp_in  = 49'($signed({1'b0, mom_ff})) * 49'(s0_vel);
   assign a_gsqp_in = 64'(s0_gabs) * 64'(s0_gabs);
   assign a_num_in  = rmspn_pkg::NUM_W'(lr_ff) * rmspn_pkg::NUM_W'(s0_gabs);

   logic                          a_valid_ff;
   rmspn_pkg::tag_type            a_tag_ff;
   logic signed [DW-1:0]          a_p_ff;
   logic                          a_gneg_ff;
   logic [rmspn_pkg::CACHE_W-1:0] a_cache_ff;
   logic signed [48:0]            a_mvp_ff;
   logic [63:0]                   a_gsqp_ff;
   logic [rmspn_pkg::NUM_W-1:0]   a_num_ff;

   always_ff @(posedge clock) begin
      if (reset) a_valid_ff <= 1'b0;
      else if (adv) a_valid_ff <= s0_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_tag_ff   <= s0_tag_ff;
         a_p_ff     <= s0_p_ff;
         a_gneg_ff  <= s0_g_ff[DW-1];
         a_cache_ff <= s0_cache;
         a_mvp_ff   <= a_mvp_in;
         a_gsqp_ff  <= a_gsqp_in;
         a_num_ff   <= a_num_in;
      end
   end

   // ---------------------------------------------------------------- stage B
   // Round m*v and g*g (half up).
   logic signed [48:0] mv_sum;
   logic [63:0]        gsq_sum;

   assign mv_sum  = a_mvp_ff + 49'sd32768;
   assign gsq_sum = a_gsqp_ff + 64'd8388608;

   logic                          b_valid_ff;
   rmspn_pkg::tag_type            b_tag_ff;
   logic signed [DW-1:0]          b_p_ff;
   logic                          b_gneg_ff;
   logic [rmspn_pkg::CACHE_W-1:0] b_cache_ff;
   logic signed [rmspn_pkg::MV_W-1:0] b_mv_ff;
   logic [rmspn_pkg::GSQ_W-1:0]   b_gsq_ff;
   logic [rmspn_pkg::NUM_W-1:0]   b_num_ff;

   always_ff @(posedge clock) begin
      if (reset) b_valid_ff <= 1'b0;
      else if (adv) b_valid_ff <= a_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         b_tag_ff   <= a_tag_ff;
         b_p_ff     <= a_p_ff;
         b_gneg_ff  <= a_gneg_ff;
         b_cache_ff <= a_cache_ff;
         b_mv_ff    <= $signed(mv_sum[48:16]);
         b_gsq_ff   <= gsq_sum[62:24];
         b_num_ff   <= a_num_ff;
      end
   end

   // ---------------------------------------------------------------- stage C
   // Square-average products, and the lookahead add or its removal.
   logic [16:0]                   inv_decay;
   logic [47:0]                   c_pd_in;
   logic [55:0]                   c_pg_in;
   rmspn_pkg::sat_type            p0_sat;
   rmspn_pkg::sat_type            la_sat;
   logic                          b_upd;

   assign inv_decay = 17'd65536 - {1'b0, decay_ff};
   assign c_pd_in   = 48'(decay_ff) * 48'(b_cache_ff);
   assign c_pg_in   = 56'(inv_decay) * 56'(b_gsq_ff);
   assign p0_sat    = rmspn_pkg::sat_data(64'(b_p_ff) - 64'(b_mv_ff));
   assign la_sat    = rmspn_pkg::sat_data(64'(b_p_ff) + 64'(b_mv_ff));
   assign b_upd     = b_tag_ff.func == rmspn_pkg::FUNC_UPDATE;

   logic                          c_valid_ff;
   rmspn_pkg::tag_type            c_tag_ff;
   logic                          c_gneg_ff;
   logic signed [DW-1:0]          c_pres_ff;
   logic                          c_flag_ff;
   logic signed [rmspn_pkg::MV_W-1:0] c_mv_ff;
   logic [rmspn_pkg::NUM_W-1:0]   c_num_ff;
   logic [47:0]                   c_pd_ff;
   logic [55:0]                   c_pg_ff;

   always_ff @(posedge clock) begin
      if (reset) c_valid_ff <= 1'b0;
      else if (adv) c_valid_ff <= b_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         c_tag_ff  <= b_tag_ff;
         c_gneg_ff <= b_gneg_ff;
         c_pres_ff <= b_upd ? p0_sat.val : la_sat.val;
         c_flag_ff <= b_upd ? p0_sat.ovf : la_sat.ovf;
         c_mv_ff   <= b_mv_ff;
         c_num_ff  <= b_num_ff;
         c_pd_ff   <= c_pd_in;
         c_pg_ff   <= c_pg_in;
      end
   end

   // ---------------------------------------------------------------- stage D
   // New square average, clamped to 32 bits; feed c * 2^24 to the root.
   logic [56:0]                   csum;
   logic [40:0]                   cs;
   logic                          c_clamp;
   logic [rmspn_pkg::CACHE_W-1:0] c_new;
   rmspn_pkg::side_type           d_side_in;

   assign csum    = 57'(c_pd_ff) + 57'(c_pg_ff) + 57'd32768;
   assign cs      = csum[56:16];
   assign c_clamp = |cs[40:32];
   assign c_new   = c_clamp ? '1 : cs[31:0];

   always_comb begin
      d_side_in.tag   = c_tag_ff;
      d_side_in.g_neg = c_gneg_ff;
      d_side_in.pres  = c_pres_ff;
      d_side_in.mv    = c_mv_ff;
      d_side_in.cache = c_new;
      d_side_in.flag  = c_flag_ff
                        | ((c_tag_ff.func == rmspn_pkg::FUNC_UPDATE) & c_clamp);
      d_side_in.num   = c_num_ff;
   end

   logic                            d_valid_ff;
   rmspn_pkg::side_type             d_side_ff;
   logic [rmspn_pkg::SQ_IN_W-1:0]   d_x_ff;

   always_ff @(posedge clock) begin
      if (reset) d_valid_ff <= 1'b0;
      else if (adv) d_valid_ff <= c_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         d_side_ff <= d_side_in;
         d_x_ff    <= {c_new, 24'd0};
      end
   end

   // ---------------------------------------------------------------- square root
   logic                          sq_valid;
   logic [rmspn_pkg::ROOT_W-1:0]  sq_root;
   rmspn_pkg::side_type           sq_side;

   rmspn_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (d_valid_ff),
      .in_x      (d_x_ff),
      .in_side   (d_side_ff),
      .probe_idx (req_bus.element_index),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_side  (sq_side),
      .hit       (sqrt_hit)
   );

   // ---------------------------------------------------------------- stage E
   // Denominator (never zero) and the dividend with half of it for rounding.
   logic [rmspn_pkg::DEN_W-1:0] den_sum;
   logic [rmspn_pkg::DEN_W-1:0] den;

   assign den_sum = rmspn_pkg::DEN_W'(sq_root) + rmspn_pkg::DEN_W'(delta_ff);
   assign den     = (den_sum == '0) ? rmspn_pkg::DEN_W'(1) : den_sum;

   logic                          e_valid_ff;
   rmspn_pkg::side_type           e_side_ff;
   logic [rmspn_pkg::DEN_W-1:0]   e_den_ff;
   logic [rmspn_pkg::DVD_W-1:0]   e_dvd_ff;

   always_ff @(posedge clock) begin
      if (reset) e_valid_ff <= 1'b0;
      else if (adv) e_valid_ff <= sq_valid;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         e_side_ff <= sq_side;
         e_den_ff  <= den;
         e_dvd_ff  <= rmspn_pkg::DVD_W'(sq_side.num) + rmspn_pkg::DVD_W'(den >> 1);
      end
   end

   // ---------------------------------------------------------------- divider
   logic                          dv_valid;
   logic [rmspn_pkg::DVD_W-1:0]   dv_quo;
   rmspn_pkg::side_type           dv_side;

   rmspn_div u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (e_valid_ff),
      .in_dvd    (e_dvd_ff),
      .in_den    (e_den_ff),
      .in_side   (e_side_ff),
      .probe_idx (req_bus.element_index),
      .out_valid (dv_valid),
      .out_quo   (dv_quo),
      .out_side  (dv_side),
      .hit       (div_hit)
   );

   // ---------------------------------------------------------------- stage F
   // Sign the step and form the new velocity.
   logic signed [rmspn_pkg::DVD_W:0] step_mag;
   logic signed [rmspn_pkg::DVD_W:0] step;
   rmspn_pkg::sat_type               vn_sat;
   rmspn_pkg::side_type              f_side_in;

   assign step_mag = $signed({1'b0, dv_quo});
   assign step     = dv_side.g_neg ? -step_mag : step_mag;
   assign vn_sat   = rmspn_pkg::sat_data(64'(dv_side.mv) - 64'(step));

   always_comb begin
      f_side_in      = dv_side;
      f_side_in.flag = dv_side.flag
                       | ((dv_side.tag.func == rmspn_pkg::FUNC_UPDATE) & vn_sat.ovf);
   end

   logic                  f_valid_ff;
   rmspn_pkg::side_type   f_side_ff;
   logic signed [DW-1:0]  f_vn_ff;

   always_ff @(posedge clock) begin
      if (reset) f_valid_ff <= 1'b0;
      else if (adv) f_valid_ff <= dv_valid;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         f_side_ff <= f_side_in;
         f_vn_ff   <= vn_sat.val;
      end
   end

   // ---------------------------------------------------------------- stage G
   // v' * (1 + m) in Q16.
   logic [16:0]        mom_one;
   logic signed [49:0] g_prod_in;

   assign mom_one   = 17'd65536 + {1'b0, mom_ff};
   assign g_prod_in = 50'(f_vn_ff) * 50'($signed({1'b0, mom_one}));

   always_ff @(posedge clock) begin
      if (reset) g_valid_ff <= 1'b0;
      else if (adv) g_valid_ff <= f_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         g_side_ff <= f_side_ff;
         g_vn_ff   <= f_vn_ff;
         g_prod_ff <= g_prod_in;
      end
   end

   // ---------------------------------------------------------------- output
   // Final add; state writes back on the same edge the result is registered.
   logic signed [49:0] prod_rnd;
   rmspn_pkg::sat_type fin_sat;
   logic               g_upd;

   assign prod_rnd = g_prod_ff + 50'sd32768;
   assign fin_sat  = rmspn_pkg::sat_data(64'(g_side_ff.pres) + 64'($signed(prod_rnd[49:16])));
   assign g_upd    = g_side_ff.tag.func == rmspn_pkg::FUNC_UPDATE;

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (adv) rsp_valid_ff <= g_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_param_ff <= g_upd ? fin_sat.val : g_side_ff.pres;
         rsp_idx_ff   <= g_side_ff.tag.idx;
         rsp_sat_ff   <= g_side_ff.flag | (g_upd & fin_sat.ovf);
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.new_parameter = rsp_param_ff;
   assign rsp_bus.result_index  = rsp_idx_ff;
   assign rsp_bus.saturated     = rsp_sat_ff;

   // ---------------------------------------------------------------- interlock
   // Hold a beat whose element has an update in flight that has not written
   // back yet; it would otherwise read stale state.
   logic [7:0] stage_hit;

   assign stage_hit[0] = rmspn_pkg::tag_hit(s0_valid_ff, s0_tag_ff, req_bus.element_index);
   assign stage_hit[1] = rmspn_pkg::tag_hit(a_valid_ff, a_tag_ff, req_bus.element_index);
   assign stage_hit[2] = rmspn_pkg::tag_hit(b_valid_ff, b_tag_ff, req_bus.element_index);
   assign stage_hit[3] = rmspn_pkg::tag_hit(c_valid_ff, c_tag_ff, req_bus.element_index);
   assign stage_hit[4] = rmspn_pkg::tag_hit(d_valid_ff, d_side_ff.tag, req_bus.element_index);
   assign stage_hit[5] = rmspn_pkg::tag_hit(e_valid_ff, e_side_ff.tag, req_bus.element_index);
   assign stage_hit[6] = rmspn_pkg::tag_hit(f_valid_ff, f_side_ff.tag, req_bus.element_index);
   assign stage_hit[7] = rmspn_pkg::tag_hit(g_valid_ff, g_side_ff.tag, req_bus.element_index);

   assign hazard = (|stage_hit) | sqrt_hit | div_hit;

endmodule

// File: tb/sv/rmsprop_nesterov_update_test.sv
module rmsprop_nesterov_update_test;

   // One expected result beat, in arrival order.
   typedef struct {
      logic signed [rmspn_pkg::DATA_W-1:0] new_parameter;
      logic [rmspn_pkg::IDX_W-1:0]         result_index;
      logic                                saturated;
   } param_result_type;

   // Tracks per-element optimizer state and predicts each result beat.
   class optimizer_scoreboard_type;
      logic [rmspn_pkg::LR_W-1:0]           lr;
      logic [rmspn_pkg::DECAY_W-1:0]        decay;
      logic [rmspn_pkg::DELTA_W-1:0]        delta;
      logic [rmspn_pkg::MOM_W-1:0]          mom;
      logic [rmspn_pkg::CACHE_W-1:0]        sq_avg [rmspn_pkg::NUM_ELEMENTS_DEF];
      logic signed [rmspn_pkg::DATA_W-1:0]  vel [rmspn_pkg::NUM_ELEMENTS_DEF];
      param_result_type                     expected_q[$];
      int                                   errors;
      int                                   n_update;
      int                                   n_lookahead;
      int                                   n_sat;

      function new();
         lr    = rmspn_pkg::LR_RESET;
         decay = rmspn_pkg::DECAY_RESET;
         delta = rmspn_pkg::DELTA_RESET;
         mom   = rmspn_pkg::MOM_RESET;
         foreach (sq_avg[i]) begin
            sq_avg[i] = '0;
            vel[i]    = '0;
         end
         errors = 0;
         n_update = 0;
         n_lookahead = 0;
         n_sat = 0;
      endfunction

      function void set_reg(logic [rmspn_pkg::CSR_IDX_W-1:0] idx,
                            logic [rmspn_pkg::CSR_W-1:0] val);
         case (idx)
            rmspn_pkg::CSR_LEARNING_RATE:   lr    = val[rmspn_pkg::LR_W-1:0];
            rmspn_pkg::CSR_DECAY_RATE:      decay = val[rmspn_pkg::DECAY_W-1:0];
            rmspn_pkg::CSR_STABILITY_DELTA: delta = val[rmspn_pkg::DELTA_W-1:0];
            rmspn_pkg::CSR_MOMENTUM:        mom   = val[rmspn_pkg::MOM_W-1:0];
            default: ;
         endcase
      endfunction

      function longint clamp(longint x, inout bit hit);
         if (x > rmspn_pkg::SAT_HI) begin
            hit = 1;
            return rmspn_pkg::SAT_HI;
         end
         if (x < rmspn_pkg::SAT_LO) begin
            hit = 1;
            return rmspn_pkg::SAT_LO;
         end
         return x;
      endfunction

      // Round half up after dropping n fraction bits.
      function longint round_shift(longint x, int n);
         return (x + (longint'(1) <<< (n - 1))) >>> n;
      endfunction

      function longint unsigned int_sqrt(longint unsigned x);
         longint unsigned r;
         longint unsigned b;
         r = 0;
         b = 64'd1 << 62;
         while (b > x) b = b >> 2;
         while (b != 0) begin
            if (x >= r + b) begin
               x = x - (r + b);
               r = (r >> 1) + b;
            end else begin
               r = r >> 1;
            end
            b = b >> 2;
         end
         return r;
      endfunction

      function void note_request(logic func, logic [rmspn_pkg::IDX_W-1:0] idx,
                                 logic signed [rmspn_pkg::DATA_W-1:0] p_in,
                                 logic signed [rmspn_pkg::DATA_W-1:0] g_in);
         param_result_type exp_beat;
         bit               hit;
         longint           p;
         longint           g;
         longint           mv;
         longint           p0;
         longint           res;
         longint           step;
         longint           vn;
         longint unsigned  ag;
         longint unsigned  gsq;
         longint unsigned  c;
         longint unsigned  den;
         longint unsigned  num;
         longint unsigned  q;
         hit = 0;
         p   = p_in;
         g   = g_in;
         mv  = round_shift(longint'(mom) * longint'(vel[idx]), 16);
         if (func == rmspn_pkg::FUNC_LOOKAHEAD) begin
            res = clamp(p + mv, hit);
            n_lookahead++;
         end else begin
            p0  = clamp(p - mv, hit);
            ag  = (g < 0) ? -g : g;
            gsq = (ag * ag + (64'd1 << 23)) >> 24;
            c   = (longint'(decay) * sq_avg[idx] + (64'd65536 - decay) * gsq
                   + 64'd32768) >> 16;
            if (c > 64'hFFFF_FFFF) begin
               c = 64'hFFFF_FFFF;
               hit = 1;
            end
            den = int_sqrt(c << 24) + delta;
            // zero denominator falls back to one
            if (den == 0) den = 1;
            num  = longint'(lr) * ag;
            q    = (num + den / 2) / den;
            step = (g < 0) ? -longint'(q) : longint'(q);
            vn   = clamp(mv - step, hit);
            res  = clamp(p0 + round_shift(vn * (64'd65536 + mom), 16), hit);
            sq_avg[idx] = c[rmspn_pkg::CACHE_W-1:0];
            vel[idx]    = vn[rmspn_pkg::DATA_W-1:0];
            n_update++;
         end
         exp_beat.new_parameter = res[rmspn_pkg::DATA_W-1:0];
         exp_beat.result_index  = idx;
         exp_beat.saturated     = hit;
         expected_q.insert(expected_q.size(), exp_beat);
      endfunction

      function void check_result(logic signed [rmspn_pkg::DATA_W-1:0] np,
                                 logic [rmspn_pkg::IDX_W-1:0] ri, logic sat_flag);
         param_result_type e;
         if (expected_q.size() == 0) begin
            $error("result beat with nothing expected: index %0d value %0d", ri, np);
            errors++;
            return;
         end
         e = expected_q.pop_front();
         if (ri !== e.result_index) begin
            $error("result_index: expected %0d actual %0d", e.result_index, ri);
            errors++;
         end
         if (np !== e.new_parameter) begin
            $error("new_parameter: expected %0d actual %0d (index %0d)",
                   e.new_parameter, np, e.result_index);
            errors++;
         end
         if (sat_flag !== e.saturated) begin
            $error("saturated: expected %0b actual %0b (index %0d)",
                   e.saturated, sat_flag, e.result_index);
            errors++;
         end
         if (e.saturated) n_sat++;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic                             clock;
   logic                             reset;
   logic                             csr_we;
   logic [rmspn_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [rmspn_pkg::CSR_W-1:0]      csr_data;

   rmspn_req_if req_bus ();
   rmspn_rsp_if rsp_bus ();

   optimizer_scoreboard_type sb;
   int                       n_settings;

   rmsprop_nesterov_update u_top (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Write one register at a falling edge, then drop the enable.
   task automatic write_reg(logic [rmspn_pkg::CSR_IDX_W-1:0] idx,
                            logic [rmspn_pkg::CSR_W-1:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      sb.set_reg(idx, val);
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   // Load a full setting; upper data bits get random junk since the block ignores them.
   task automatic load_setting(int unsigned lr_v, int unsigned dec_v, int unsigned del_v,
                               int unsigned mom_v);
      logic [rmspn_pkg::CSR_W-1:0] junk;
      junk = $urandom;
      write_reg(rmspn_pkg::CSR_LEARNING_RATE,
                {junk[rmspn_pkg::CSR_W-1:rmspn_pkg::LR_W], lr_v[rmspn_pkg::LR_W-1:0]});
      junk = $urandom;
      write_reg(rmspn_pkg::CSR_DECAY_RATE,
                {junk[rmspn_pkg::CSR_W-1:rmspn_pkg::DECAY_W],
                 dec_v[rmspn_pkg::DECAY_W-1:0]});
      write_reg(rmspn_pkg::CSR_STABILITY_DELTA, del_v[rmspn_pkg::DELTA_W-1:0]);
      junk = $urandom;
      write_reg(rmspn_pkg::CSR_MOMENTUM,
                {junk[rmspn_pkg::CSR_W-1:rmspn_pkg::MOM_W], mom_v[rmspn_pkg::MOM_W-1:0]});
      n_settings++;
   endtask

   // Hold a request beat until it is taken; gaps drop valid first.
   task automatic send_beat(logic func, logic [rmspn_pkg::IDX_W-1:0] idx,
                            logic signed [rmspn_pkg::DATA_W-1:0] p,
                            logic signed [rmspn_pkg::DATA_W-1:0] g);
      int gap;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
      if ($urandom_range(0, 1) == 0) gap = 0;
      repeat (gap) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
      end
      @(negedge clock);
      req_bus.valid           <= 1'b1;
      req_bus.func            <= func;
      req_bus.element_index   <= idx;
      req_bus.parameter_value <= p;
      req_bus.gradient_value  <= g;
      do @(posedge clock); while (!req_bus.ready);
      sb.note_request(func, idx, p, g);
   endtask

   task automatic stop_sending();
      @(negedge clock);
      req_bus.valid <= 1'b0;
   endtask

   // Wait until every expected beat is back, plus the pipe depth, before touching registers.
   task automatic drain();
      while (sb.pending() != 0) @(posedge clock);
      repeat (120) @(posedge clock);
   endtask

   // Random gradient: mostly modest magnitudes so the state evolves, some full range.
   function automatic logic signed [rmspn_pkg::DATA_W-1:0] pick_value();
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return $signed($urandom_range(0, 32'h01FF_FFFF)) - 32'sh0100_0000;
         2: return $signed($urandom_range(0, 4095)) - 32'sd2048;
         default: return $signed($urandom_range(0, 32'h1FFF_FFFF)) - 32'sh1000_0000;
      endcase
   endfunction

   task automatic random_phase(int count);
      logic [rmspn_pkg::IDX_W-1:0] idx;
      for (int i = 0; i < count; i++) begin
         // keep most traffic on a few hot elements so state and hazards build up
         idx = ($urandom_range(0, 3) != 0) ? rmspn_pkg::IDX_W'($urandom_range(0, 15))
                                           : rmspn_pkg::IDX_W'($urandom);
         send_beat($urandom_range(0, 2) != 0 ? rmspn_pkg::FUNC_UPDATE
                                             : rmspn_pkg::FUNC_LOOKAHEAD,
                   idx, pick_value(), pick_value());
      end
      stop_sending();
   endtask

   // Result side: draw a stall per beat, check every accepted beat.
   initial begin
      int stall;
      rsp_bus.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 16);
         repeat (stall) begin
            @(negedge clock);
            rsp_bus.ready <= 1'b0;
         end
         @(negedge clock);
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
         sb.check_result(rsp_bus.new_parameter, rsp_bus.result_index, rsp_bus.saturated);
      end
   end

   initial begin
      #20000000;
      $display("rmsprop_nesterov_update regression: fail");
      $finish;
   end

   initial begin
      sb = new();
      n_settings = 0;
      reset                   = 1'b1;
      csr_we                  = 1'b0;
      csr_index               = '0;
      csr_data                = '0;
      req_bus.valid           = 1'b0;
      req_bus.func            = rmspn_pkg::FUNC_LOOKAHEAD;
      req_bus.element_index   = '0;
      req_bus.parameter_value = '0;
      req_bus.gradient_value  = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part under reset defaults: extremes, both operations, hot element.
      send_beat(rmspn_pkg::FUNC_LOOKAHEAD, 12'd0, 32'sh7FFF_FFFF, 32'sh8000_0000);
      send_beat(rmspn_pkg::FUNC_UPDATE, 12'd0, 32'sh0100_0000, 32'sh0100_0000);
      send_beat(rmspn_pkg::FUNC_UPDATE, 12'd0, 32'sh0100_0000, 32'sh0100_0000);
      send_beat(rmspn_pkg::FUNC_LOOKAHEAD, 12'd0, 32'sh0000_0000, 32'sh0);
      send_beat(rmspn_pkg::FUNC_UPDATE, 12'd4095, 32'sh7FFF_FFFF, 32'sh8000_0000);
      send_beat(rmspn_pkg::FUNC_UPDATE, 12'd4095, 32'sh8000_0000, 32'sh7FFF_FFFF);
      send_beat(rmspn_pkg::FUNC_UPDATE, 12'd4095, 32'sh8000_0000, 32'sh7FFF_FFFF);
      send_beat(rmspn_pkg::FUNC_LOOKAHEAD, 12'd4095, 32'sh8000_0000, 32'sh0);
      send_beat(rmspn_pkg::FUNC_UPDATE, 12'd1, 32'sh0, 32'sh0);
      send_beat(rmspn_pkg::FUNC_UPDATE, 12'd2, 32'sh7FFF_FFFF, 32'shFFFF_FFFF);
      send_beat(rmspn_pkg::FUNC_UPDATE, 12'd2, 32'sh7FFF_FFFF, 32'shFFFF_FFFF);
      stop_sending();
      drain();

      // Largest rate and momentum, zero decay: cache follows the squared gradient.
      load_setting(24'hFF_FFFF, 0, 1, 16'hFFFF);
      send_beat(rmspn_pkg::FUNC_UPDATE, 12'd3, 32'sh0, 32'sh7FFF_FFFF);
      send_beat(rmspn_pkg::FUNC_UPDATE, 12'd3, 32'sh0, 32'sh8000_0000);
      send_beat(rmspn_pkg::FUNC_LOOKAHEAD, 12'd3, 32'sh7FFF_FFFF, 32'sh0);
      send_beat(rmspn_pkg::FUNC_UPDATE, 12'd5, 32'sh0, 32'sh1);
      stop_sending();
      drain();

      // Zero delta on an empty cache: the divider falls back to one.
      load_setting(24'hFF_FFFF, 16'hFFFF, 0, 1);
      send_beat(rmspn_pkg::FUNC_UPDATE, 12'd100, 32'sh10, 32'sh1);
      send_beat(rmspn_pkg::FUNC_UPDATE, 12'd101, 32'sh10, -32'sh1);
      send_beat(rmspn_pkg::FUNC_UPDATE, 12'd102, 32'sh10, 32'sh0);
      stop_sending();
      drain();

      // Zero rate gives a zero step; widest delta.
      load_setting(0, 1, 25'h1FF_FFFF, 0);
      send_beat(rmspn_pkg::FUNC_UPDATE, 12'd6, 32'sh0123_4567, 32'sh7654_3210);
      send_beat(rmspn_pkg::FUNC_LOOKAHEAD, 12'd6, 32'sh0123_4567, 32'sh0);
      stop_sending();
      drain();

      // Random phases, each under its own setting.
      load_setting(rmspn_pkg::LR_RESET, rmspn_pkg::DECAY_RESET, rmspn_pkg::DELTA_RESET,
                   rmspn_pkg::MOM_RESET);
      random_phase(200);
      drain();
      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: load_setting(24'hFF_FFFF, 16'hFFFF, 1, 16'hFFFF);
            1: load_setting(1, 1, 25'h100_0000, 1);
            2: load_setting(0, 0, 0, 16'hFFFF);
            default: load_setting($urandom_range(1, 24'hFF_FFFF), $urandom_range(1, 16'hFFFF),
                                  $urandom_range(1, 25'h100_0000), $urandom_range(1, 16'hFFFF));
         endcase
         random_phase(200);
         drain();
      end

      $display("covered %0d updates and %0d lookaheads over %0d register settings",
               sb.n_update, sb.n_lookahead, n_settings);
      $display("%0d results came back saturated, %0d mismatches", sb.n_sat, sb.errors);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("rmsprop_nesterov_update regression: pass");
      end else begin
         $display("rmsprop_nesterov_update regression: fail");
      end
      $finish;
   end

endmodule
